/* rtl/core/gpwa_pkg.sv */
// shared widths, register codes and reset values of the window average block
package gpwa_pkg;

   localparam int ANCHOR_COUNT_DEFAULT = 8;
   localparam int WINDOW_MAX_DEFAULT   = 16;

   // port field widths
   localparam int ANCHOR_W      = 3;
   localparam int DIST_W        = 16;
   localparam int SAMPLES_W     = 5;
   localparam int WITH_DATA_W   = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // register widths
   localparam int WINDOW_REG_W  = 5;
   localparam int MASK_W        = 8;
   localparam int MIN_REG_W     = 4;

   // register reset values
   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET   = 5'd5;
   localparam logic [DIST_W-1:0]       MAX_DIST_RESET = 16'd20000;
   localparam logic [MASK_W-1:0]       MASK_RESET     = 8'd0;
   localparam logic [MIN_REG_W-1:0]    MIN_RESET      = 4'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_MAX_DISTANCE  = 2'd1,
      CSR_ANCHOR_MASK   = 2'd2,
      CSR_MIN_ANCHORS   = 2'd3
   } csr_index_type;

endpackage

/* rtl/core/gpwa_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
module gpwa_divider #(
   parameter int DIVIDEND_W = 21,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // quotient bits shift in where the dividend shifts out
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = diff[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
            step_ff <= STEP_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/gated_per_channel_window_average.sv */
// top level: range gate, per-anchor sliding window and truncated average
//
//   port group  dir   handshake              word
//   req_        in    req_valid/req_ready    anchor index, distance
//   rsp_        out   rsp_valid/rsp_ready    flag, average, counts
//   csr_        in    csr_write_enable       register index, data
//
// an item passes through the idle, meta, store, divide and result states, the
// average coming from the one-bit-per-cycle divider; no new req_ word is taken until idle.
// reset clears the per-anchor valid bits at once; the reading memory is not
// cleared and only written slots are ever used.
// a finished word waits in the rsp_ register while the next req_ word is taken;
// a stalled rsp_ side holds the block in its result state.
module gated_per_channel_window_average #(
   parameter int ANCHOR_COUNT = gpwa_pkg::ANCHOR_COUNT_DEFAULT,
   parameter int WINDOW_MAX   = gpwa_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gpwa_pkg::ANCHOR_W-1:0]    req_anchor_index,
   input  logic [gpwa_pkg::DIST_W-1:0]      req_distance_mm,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [gpwa_pkg::DIST_W-1:0]      rsp_average_mm,
   output logic [gpwa_pkg::SAMPLES_W-1:0]   rsp_anchor_samples,
   output logic [gpwa_pkg::WITH_DATA_W-1:0] rsp_anchors_with_data,
   output logic                             rsp_enough_anchors,
   input  logic                             csr_write_enable,
   input  logic [gpwa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpwa_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import gpwa_pkg::*;

   localparam int AW     = $clog2(ANCHOR_COUNT);
   localparam int SW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW     = $clog2(WINDOW_MAX + 1);
   localparam int TW     = CW + 1;
   localparam int SUMW   = DIST_W + CW;
   localparam int DEPTH  = ANCHOR_COUNT * WINDOW_MAX;
   localparam int SAW    = $clog2(DEPTH);
   localparam int MASK_N = (ANCHOR_COUNT < MASK_W) ? ANCHOR_COUNT : MASK_W;

   typedef struct packed {
      logic [SW-1:0]   oldest;
      logic [CW-1:0]   count;
      logic [SUMW-1:0] sum;
   } meta_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_META,
      S_STORE,
      S_DIVIDE,
      S_RESULT
   } state_type;

   // configuration
   logic [WINDOW_REG_W-1:0] window_length_ff;
   logic [DIST_W-1:0]       max_distance_ff;
   logic [MASK_W-1:0]       anchor_mask_ff;
   logic [MIN_REG_W-1:0]    min_anchors_ff;

   // memories
   meta_type                meta_mem [ANCHOR_COUNT];
   logic [DIST_W-1:0]       store_mem [DEPTH];
   logic [ANCHOR_COUNT-1:0] meta_valid_ff;
   meta_type                meta_rd_ff;
   logic                    meta_rd_valid_ff;
   logic [DIST_W-1:0]       store_rd_ff;

   // sequencer
   state_type               state_ff;
   logic [ANCHOR_W-1:0]     anchor_ff;
   logic [DIST_W-1:0]       distance_ff;
   logic                    in_range_ff;
   logic                    gate_ff;
   logic                    full_ff;
   logic [SW-1:0]           slot_ff;
   logic [SAW-1:0]          store_addr_ff;
   meta_type                meta_ff;
   logic [CW-1:0]           cnt_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_accepted_ff;
   logic [DIST_W-1:0]       rsp_average_ff;
   logic [SAMPLES_W-1:0]    rsp_samples_ff;
   logic [WITH_DATA_W-1:0]  rsp_with_data_ff;
   logic                    rsp_enough_ff;

   logic                    accept;
   logic [AW-1:0]           anchor_addr;
   logic [CW-1:0]           win;
   meta_type                cur;
   logic                    gate;
   logic                    full;
   logic [TW-1:0]           fill_pos;
   logic [SW-1:0]           slot;
   logic [SAW-1:0]          store_addr;
   logic [DIST_W-1:0]       old_reading;
   meta_type                meta_new;
   logic [TW-1:0]           next_pos;
   logic [SUMW-1:0]         div_dividend;
   logic [CW-1:0]           div_divisor;
   logic                    div_start;
   logic                    div_done;
   logic [SUMW-1:0]         div_quotient;
   logic [WITH_DATA_W-1:0]  with_data;
   logic                    meta_we;

   assign accept      = req_valid && (state_ff == S_IDLE);
   assign anchor_addr = AW'(anchor_ff);

   // register value zero acts as one, values past the store depth saturate
   always_comb begin
      if (window_length_ff == '0) begin
         win = CW'(1);
      end else if (int'(window_length_ff) > WINDOW_MAX) begin
         win = CW'(WINDOW_MAX);
      end else begin
         win = CW'(window_length_ff);
      end
   end

   // gate and slot choice from the anchor's state
   always_comb begin
      cur  = meta_rd_valid_ff ? meta_rd_ff : '0;
      gate = in_range_ff && (distance_ff != '0) && (distance_ff <= max_distance_ff);
      full = (cur.count >= win);
      fill_pos = TW'(cur.oldest) + TW'(cur.count);
      if (fill_pos >= TW'(win)) begin
         fill_pos = fill_pos - TW'(win);
      end
      slot       = full ? cur.oldest : SW'(fill_pos);
      store_addr = SAW'(int'(anchor_addr) * WINDOW_MAX + int'(slot));
   end

   // new window state once the displaced reading is back
   always_comb begin
      old_reading = full_ff ? store_rd_ff : '0;
      next_pos    = TW'(slot_ff) + TW'(1);
      meta_new.sum = meta_ff.sum - SUMW'(old_reading) + SUMW'(distance_ff);
      if (full_ff) begin
         meta_new.count  = meta_ff.count;
         meta_new.oldest = (next_pos >= TW'(win)) ? '0 : SW'(next_pos);
      end else begin
         meta_new.count  = meta_ff.count + 1'b1;
         meta_new.oldest = meta_ff.oldest;
      end
      div_dividend = gate_ff ? meta_new.sum : meta_ff.sum;
      div_divisor  = gate_ff ? meta_new.count : meta_ff.count;
   end

   assign div_start = (state_ff == S_STORE);
   assign meta_we   = (state_ff == S_STORE) && gate_ff;

   always_comb begin
      with_data = '0;
      for (int i = 0; i < MASK_N; i++) begin
         if (meta_valid_ff[i] && anchor_mask_ff[i]) begin
            with_data = with_data + 1'b1;
         end
      end
   end

   gpwa_divider #(
      .DIVIDEND_W (SUMW),
      .DIVISOR_W  (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // per-anchor state; the sequencer never reads an entry in the cycle it is
   // written, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[anchor_addr] <= meta_new;
      end
      if (accept) begin
         meta_rd_ff <= meta_mem[AW'(req_anchor_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_valid_ff    <= '0;
         meta_rd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            meta_rd_valid_ff <= meta_valid_ff[AW'(req_anchor_index)];
         end
         if (csr_write_enable && (csr_index == CSR_WINDOW_LENGTH)) begin
            meta_valid_ff <= '0;
         end else if (meta_we) begin
            meta_valid_ff[anchor_addr] <= 1'b1;
         end
      end
   end

   // reading memory
   always_ff @(posedge clock) begin
      if (state_ff == S_META) begin
         store_rd_ff <= store_mem[store_addr];
      end
      if (meta_we) begin
         store_mem[store_addr_ff] <= distance_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
         max_distance_ff  <= MAX_DIST_RESET;
         anchor_mask_ff   <= MASK_RESET;
         min_anchors_ff   <= MIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_write_data[WINDOW_REG_W-1:0];
            CSR_MAX_DISTANCE:  max_distance_ff  <= csr_write_data[DIST_W-1:0];
            CSR_ANCHOR_MASK:   anchor_mask_ff   <= csr_write_data[MASK_W-1:0];
            CSR_MIN_ANCHORS:   min_anchors_ff   <= csr_write_data[MIN_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the result state loads the register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  anchor_ff   <= req_anchor_index;
                  distance_ff <= req_distance_mm;
                  in_range_ff <= (int'(req_anchor_index) < ANCHOR_COUNT);
                  state_ff    <= S_META;
               end
            end
            S_META: begin
               meta_ff       <= cur;
               gate_ff       <= gate;
               full_ff       <= full;
               slot_ff       <= slot;
               store_addr_ff <= store_addr;
               state_ff      <= S_STORE;
            end
            S_STORE: begin
               cnt_ff   <= in_range_ff ? div_divisor : '0;
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               if (div_done) begin
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_accepted_ff  <= gate_ff;
                  rsp_average_ff   <= (cnt_ff == '0) ? '0 : div_quotient[DIST_W-1:0];
                  rsp_samples_ff   <= SAMPLES_W'(cnt_ff);
                  rsp_with_data_ff <= with_data;
                  rsp_enough_ff    <= (with_data >= min_anchors_ff);
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_accepted_ff;
   assign rsp_average_mm        = rsp_average_ff;
   assign rsp_anchor_samples    = rsp_samples_ff;
   assign rsp_anchors_with_data = rsp_with_data_ff;
   assign rsp_enough_anchors    = rsp_enough_ff;

endmodule

/* rtl/core/gpwa_checker.sv */
// port-level checks of the window average block, bound to the top level
module gpwa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_accepted,
   input logic [gpwa_pkg::DIST_W-1:0]      rsp_average_mm,
   input logic [gpwa_pkg::SAMPLES_W-1:0]   rsp_anchor_samples,
   input logic [gpwa_pkg::WITH_DATA_W-1:0] rsp_anchors_with_data,
   input logic                             rsp_enough_anchors
);

   // no word is offered in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_mm)
         && $stable(rsp_anchor_samples) && $stable(rsp_accepted)
         && $stable(rsp_anchors_with_data) && $stable(rsp_enough_anchors))
      else $error("stalled result word changed");

   // a stored reading leaves at least one sample in its window
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_anchor_samples != '0)
      else $error("accepted reading with empty window");

   // an empty window averages to zero
   a_empty_average: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_anchor_samples == '0) |-> rsp_average_mm == '0)
      else $error("nonzero average of empty window");

endmodule

bind gated_per_channel_window_average gpwa_checker u_gpwa_checker (.*);

/* tb/window_average_checker.sv */
// checker: predicts every result word of the window average block and compares it
module window_average_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [gpwa_pkg::ANCHOR_W-1:0]    req_anchor_index,
   input  logic [gpwa_pkg::DIST_W-1:0]      req_distance_mm,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_accepted,
   input  logic [gpwa_pkg::DIST_W-1:0]      rsp_average_mm,
   input  logic [gpwa_pkg::SAMPLES_W-1:0]   rsp_anchor_samples,
   input  logic [gpwa_pkg::WITH_DATA_W-1:0] rsp_anchors_with_data,
   input  logic                             rsp_enough_anchors,
   input  logic                             csr_write_enable,
   input  logic [gpwa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpwa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               failures,
   output int                               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gpwa_pkg::*;

   localparam int ANCHORS       = ANCHOR_COUNT_DEFAULT;
   localparam int SLOTS         = WINDOW_MAX_DEFAULT;
   localparam int PENDING_DEPTH = 8;

   typedef struct packed {
      logic                   accepted;
      logic [DIST_W-1:0]      average_mm;
      logic [SAMPLES_W-1:0]   anchor_samples;
      logic [WITH_DATA_W-1:0] anchors_with_data;
      logic                   enough_anchors;
   } window_word_type;

   // per-anchor circular windows
   logic [DIST_W-1:0]    readings [ANCHORS][SLOTS];
   logic [3:0]           first_slot [ANCHORS];
   logic [SAMPLES_W-1:0] held [ANCHORS];
   logic [19:0]          total [ANCHORS];

   logic [WINDOW_REG_W-1:0] window_cfg;
   logic [DIST_W-1:0]       max_dist_cfg;
   logic [MASK_W-1:0]       mask_cfg;
   logic [MIN_REG_W-1:0]    min_cfg;

   // expected words in order of acceptance
   window_word_type pending_words [PENDING_DEPTH];
   int head_idx = 0;
   int tail_idx = 0;
   int pending_count = 0;
   int reported = 0;

   function automatic void clear_windows();
      for (int i = 0; i < ANCHORS; i++) begin
         held[i] = '0;
         total[i] = '0;
         first_slot[i] = '0;
      end
   endfunction

   function automatic window_word_type predict_reading(input logic [ANCHOR_W-1:0] anchor,
                                                       input logic [DIST_W-1:0] reading_mm);
      window_word_type w;
      int unsigned win;
      int unsigned slot;
      int unsigned a;
      int with_data;
      w = '0;
      a = anchor;
      with_data = 0;
      // zero length acts as one, anything above the store depth saturates
      if (window_cfg == 0)
         win = 1;
      else if (window_cfg > SLOTS)
         win = SLOTS;
      else
         win = window_cfg;
      if (a < ANCHORS && reading_mm != 0 && reading_mm <= max_dist_cfg) begin
         w.accepted = 1'b1;
         if (held[a] > win) held[a] = SAMPLES_W'(win);
         if (held[a] < win) begin
            slot = (first_slot[a] + held[a]) % win;
            readings[a][slot] = reading_mm;
            total[a] = total[a] + reading_mm;
            held[a] = held[a] + 1'b1;
         end else begin
            // full window: overwrite the oldest reading
            slot = first_slot[a] % win;
            total[a] = total[a] - readings[a][slot] + reading_mm;
            readings[a][slot] = reading_mm;
            first_slot[a] = 4'((slot + 1) % win);
         end
      end
      if (a < ANCHORS) begin
         w.anchor_samples = held[a];
         if (held[a] != 0) w.average_mm = DIST_W'(total[a] / held[a]);
      end
      for (int i = 0; i < ANCHORS && i < MASK_W; i++)
         if (mask_cfg[i] && held[i] != 0) with_data++;
      w.anchors_with_data = WITH_DATA_W'(with_data);
      w.enough_anchors = (with_data >= min_cfg);
      return w;
   endfunction

   always @(posedge clock) begin
      window_word_type got;
      window_word_type want;
      window_word_type next_word;
      if (reset) begin
         window_cfg = WINDOW_RESET;
         max_dist_cfg = MAX_DIST_RESET;
         mask_cfg = MASK_RESET;
         min_cfg = MIN_RESET;
         clear_windows();
         head_idx = 0;
         tail_idx = 0;
         pending_count = 0;
         failures = 0;
         reported = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: begin
                  window_cfg = csr_write_data[WINDOW_REG_W-1:0];
                  clear_windows();
               end
               CSR_MAX_DISTANCE: max_dist_cfg = csr_write_data;
               CSR_ANCHOR_MASK:  mask_cfg = csr_write_data[MASK_W-1:0];
               CSR_MIN_ANCHORS:  min_cfg = csr_write_data[MIN_REG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_average_mm, rsp_anchor_samples,
                   rsp_anchors_with_data, rsp_enough_anchors};
            if (pending_count == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: result word with none pending: acc %0d avg %0d samples %0d",
                           $realtime, got.accepted, got.average_mm, got.anchor_samples);
                  $display("   with_data %0d enough %0d",
                           got.anchors_with_data, got.enough_anchors);
               end
            end else begin
               want = pending_words[head_idx];
               head_idx = (head_idx + 1) % PENDING_DEPTH;
               pending_count--;
               if (got.accepted !== want.accepted || got.average_mm !== want.average_mm ||
                   got.anchor_samples !== want.anchor_samples ||
                   got.anchors_with_data !== want.anchors_with_data ||
                   got.enough_anchors !== want.enough_anchors) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: result word mismatch", $realtime);
                     $display("   expected acc %0d avg %0d samples %0d with_data %0d enough %0d",
                              want.accepted, want.average_mm, want.anchor_samples,
                              want.anchors_with_data, want.enough_anchors);
                     $display("   actual   acc %0d avg %0d samples %0d with_data %0d enough %0d",
                              got.accepted, got.average_mm, got.anchor_samples,
                              got.anchors_with_data, got.enough_anchors);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            next_word = predict_reading(req_anchor_index, req_distance_mm);
            if (pending_count == PENDING_DEPTH) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: too many words outstanding", $realtime);
               end
            end else begin
               pending_words[tail_idx] = next_word;
               tail_idx = (tail_idx + 1) % PENDING_DEPTH;
               pending_count++;
            end
         end
      end
      results_pending = pending_count;
   end

endmodule

/* tb/gated_per_channel_window_average_tb.sv */
// testbench top: reading stimulus, config phases, flow control and verdict
module gated_per_channel_window_average_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gpwa_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [ANCHOR_W-1:0]    req_anchor_index;
   logic [DIST_W-1:0]      req_distance_mm;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_accepted;
   logic [DIST_W-1:0]      rsp_average_mm;
   logic [SAMPLES_W-1:0]   rsp_anchor_samples;
   logic [WITH_DATA_W-1:0] rsp_anchors_with_data;
   logic                   rsp_enough_anchors;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int failures;
   int results_pending;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_length = 0;
   int hold_served = 0;
   int hold_left = 0;

   gated_per_channel_window_average dut (.*);

   window_average_checker window_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = hold_length;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_reading(input logic [ANCHOR_W-1:0] anchor,
                               input logic [DIST_W-1:0] reading_mm);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_anchor_index <= anchor;
      req_distance_mm <= reading_mm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [DIST_W-1:0]       max_dist;
      logic [DIST_W-1:0]       reading_mm;
      logic [WINDOW_REG_W-1:0] win;
      logic [MIN_REG_W-1:0]    min_needed;
      logic [MASK_W-1:0]       mask;
      int r;
      int span;
      reset = 1'b1;
      req_valid = 1'b0;
      req_anchor_index = '0;
      req_distance_mm = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero, the threshold and just above it, disabled anchors
      send_reading(3'd0, 16'd0);
      send_reading(3'd0, 16'd20000);
      send_reading(3'd0, 16'd20001);
      send_reading(3'd1, 16'hFFFF);
      send_reading(3'd7, 16'd1);

      wait_for_results();
      write_register(CSR_WINDOW_LENGTH, 16'd16);
      write_register(CSR_MAX_DISTANCE, 16'hFFFF);
      write_register(CSR_ANCHOR_MASK, 16'h00A5);
      write_register(CSR_MIN_ANCHORS, 16'd0);
      send_reading(3'd0, 16'hFFFF);
      send_reading(3'd0, 16'hFFFF);
      send_reading(3'd2, 16'd1);
      send_reading(3'd5, 16'hFFFF);
      send_reading(3'd6, 16'd12345);

      // zero window length, zero threshold, min above the anchor count
      wait_for_results();
      write_register(CSR_WINDOW_LENGTH, 16'd0);
      write_register(CSR_MAX_DISTANCE, 16'd0);
      write_register(CSR_MIN_ANCHORS, 16'd9);
      send_reading(3'd3, 16'd1);
      send_reading(3'd3, 16'hFFFF);
      send_reading(3'd0, 16'd0);

      // oversized window length, threshold of one, every anchor needed
      wait_for_results();
      write_register(CSR_WINDOW_LENGTH, 16'd31);
      write_register(CSR_MAX_DISTANCE, 16'd1);
      write_register(CSR_ANCHOR_MASK, 16'h00FF);
      write_register(CSR_MIN_ANCHORS, 16'd8);
      for (int i = 0; i < 8; i++) send_reading(ANCHOR_W'(i), 16'd1);
      send_reading(3'd4, 16'd2);

      for (int phase = 0; phase < 16; phase++) begin
         wait_for_results();
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin req_idle_pct = 12; rsp_stall_pct = 12; end
         endcase

         // skipping the window write lets windows carry over between phases
         if (phase == 0 || $urandom_range(1) == 1) begin
            r = $urandom_range(99);
            if (r < 10) win = '0;
            else if (r < 20) win = WINDOW_REG_W'($urandom_range(31, 17));
            else if (r < 30) win = 5'd16;
            else if (r < 40) win = 5'd1;
            else win = WINDOW_REG_W'($urandom_range(16, 1));
            write_register(CSR_WINDOW_LENGTH, CSR_DATA_W'(win));
         end
         r = $urandom_range(99);
         if (r < 8) max_dist = '0;
         else if (r < 45) max_dist = 16'hFFFF;
         else if (r < 60) max_dist = 16'd20000;
         else if (r < 75) max_dist = DIST_W'($urandom_range(255, 1));
         else max_dist = DIST_W'($urandom_range(65535, 1));
         write_register(CSR_MAX_DISTANCE, max_dist);
         r = $urandom_range(99);
         if (r < 15) mask = 8'hFF;
         else mask = MASK_W'($urandom_range(255));
         write_register(CSR_ANCHOR_MASK, CSR_DATA_W'(mask));
         r = $urandom_range(99);
         if (r < 15) min_needed = '0;
         else if (r < 25) min_needed = MIN_REG_W'($urandom_range(15, 9));
         else min_needed = MIN_REG_W'($urandom_range(8, 1));
         write_register(CSR_MIN_ANCHORS, CSR_DATA_W'(min_needed));

         // few anchors fill deep windows, all anchors spread the readings
         r = $urandom_range(2);
         span = (r == 0) ? 1 : (r == 1) ? 3 : 7;

         // long result hold-off while words keep coming, so the input backs up
         if (phase == 4 || phase == 12) begin
            @(posedge clock);
            hold_length = 400;
            hold_requests++;
         end

         for (int n = 0; n < 115; n++) begin
            if (phase % 3 == 1 && n == 57) wait_for_results();
            r = $urandom_range(99);
            if (r < 4) reading_mm = '0;
            else if (r < 8) reading_mm = 16'hFFFF;
            else if (r < 14) reading_mm = max_dist;
            else if (r < 20)
               reading_mm = (max_dist == 16'hFFFF) ? max_dist : max_dist + 1'b1;
            else if (r < 24) reading_mm = 16'd1;
            else if (max_dist == 0) reading_mm = DIST_W'($urandom_range(65535));
            else reading_mm = DIST_W'($urandom_range(max_dist, 1));
            send_reading(ANCHOR_W'($urandom_range(span)), reading_mm);
         end
      end

      wait_for_results();
      repeat (60) @(negedge clock);
      if (failures == 0 && results_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
rtl/core/gpwa_pkg.sv
rtl/core/gpwa_divider.sv
rtl/core/gated_per_channel_window_average.sv
rtl/core/gpwa_checker.sv
tb/window_average_checker.sv
tb/gated_per_channel_window_average_tb.sv
